@@ rtl/pbwc_pkg.sv @@
`timescale 1ns / 1ps
package pbwc_pkg;

    localparam int WORD_BITS  = 8;
    localparam int HIST_BITS  = 3 * WORD_BITS;
    localparam int ROT_BITS   = $clog2(2 * WORD_BITS);
    localparam int OFS_BITS   = 3;
    localparam int S_FIELDS   = 5 * WORD_BITS;
    localparam int S_DATA_W   = ((S_FIELDS + 7) / 8) * 8;
    localparam int M_DATA_W   = ((WORD_BITS + 7) / 8) * 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = OFS_BITS;
    localparam int Q_DEPTH    = 2;
    localparam int Q_AW       = $clog2(Q_DEPTH);
    localparam int Q_CW       = $clog2(Q_DEPTH + 1);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FILL_MODE  = 2'd0,
        REG_DST_OFFSET = 2'd1,
        REG_SRC_OFFSET = 2'd2,
        REG_END_PAD    = 2'd3
    } t_reg_idx;

    typedef struct packed {
        logic                fill_mode;
        logic [OFS_BITS-1:0] dst_bit_offset;
        logic [OFS_BITS-1:0] src_bit_offset;
        logic [OFS_BITS-1:0] end_pad_bits;
    } t_cfg;

    typedef struct packed {
        logic [WORD_BITS-1:0] aligned;
        logic [WORD_BITS-1:0] mask;
        logic [WORD_BITS-1:0] old_dst;
        logic [WORD_BITS-1:0] fg;
        logic [WORD_BITS-1:0] bg;
        logic                 last;
    } t_entry;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_ctl;

endpackage

@@ rtl/pbwc_front.sv @@
`timescale 1ns / 1ps
module pbwc_front import pbwc_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_cfg                 i_cfg,
    input  logic                 i_first,
    input  logic                 i_last,
    input  logic [WORD_BITS-1:0] i_src,
    input  logic [WORD_BITS-1:0] i_src2,
    input  logic [WORD_BITS-1:0] i_old,
    input  logic [WORD_BITS-1:0] i_fg,
    input  logic [WORD_BITS-1:0] i_bg,
    input  logic                 i_valid,
    input  logic                 i_full,
    output logic                 o_ready,
    output logic                 o_push,
    output t_entry               o_entry
);

    localparam logic [WORD_BITS-1:0] ONES = {WORD_BITS{1'b1}};

    logic [HIST_BITS-1:0] r_hist;
    logic [HIST_BITS-1:0] n_hist;
    logic [ROT_BITS-1:0]  rot;
    logic [WORD_BITS-1:0] mask;

    assign o_ready = !i_full;
    assign o_push  = i_valid && !i_full;

    always_comb begin
        if (i_first) begin
            n_hist = {{WORD_BITS{1'b0}}, i_src, i_src2};
        end else begin
            n_hist = {r_hist[2*WORD_BITS-1:0], i_src};
        end
        rot = (ROT_BITS'(i_cfg.dst_bit_offset) - ROT_BITS'(i_cfg.src_bit_offset))
              ^ ROT_BITS'(WORD_BITS);
        mask = ONES;
        if (i_first) begin
            mask = mask & (ONES >> i_cfg.dst_bit_offset);
        end
        if (i_last) begin
            mask = mask & (ONES << i_cfg.end_pad_bits);
        end
        o_entry.aligned = WORD_BITS'(n_hist >> rot);
        o_entry.mask    = mask;
        o_entry.old_dst = i_old;
        o_entry.fg      = i_fg;
        o_entry.bg      = i_bg;
        o_entry.last    = i_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hist <= '0;
        end else if (o_push) begin
            r_hist <= n_hist;
        end
    end

endmodule

@@ rtl/pbwc_queue.sv @@
`timescale 1ns / 1ps
module pbwc_queue import pbwc_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  logic   i_pop,
    input  t_entry i_entry,
    output t_entry o_entry,
    output t_q_ctl o_ctl
);

    t_entry            r_mem [Q_DEPTH];
    logic [Q_AW-1:0]   r_wr;
    logic [Q_AW-1:0]   r_rd;
    logic [Q_CW-1:0]   r_cnt;

    assign o_ctl.full  = (r_cnt == Q_CW'(Q_DEPTH));
    assign o_ctl.empty = (r_cnt == '0);
    assign o_entry     = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == Q_AW'(Q_DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= (r_rd == Q_AW'(Q_DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= Q_CW'(Q_DEPTH))
        else $error("queue count beyond depth");

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ctl.full |-> !i_push)
        else $error("push into full queue");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ctl.empty |-> !i_pop)
        else $error("pop from empty queue");

    a_cnt_grow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && !i_pop) |=> (r_cnt == $past(r_cnt) + 1'b1))
        else $error("queue count did not advance on push");

endmodule

@@ rtl/pbwc_back.sv @@
`timescale 1ns / 1ps
module pbwc_back import pbwc_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_fill_mode,
    input  t_entry               i_entry,
    input  logic                 i_empty,
    input  logic                 i_tready,
    output logic                 o_pop,
    output logic                 o_valid,
    output logic [WORD_BITS-1:0] o_word,
    output logic                 o_last
);

    logic                 r_valid;
    logic [WORD_BITS-1:0] r_word;
    logic                 r_last;
    logic [WORD_BITS-1:0] val;
    logic [WORD_BITS-1:0] n_word;

    assign o_pop   = !i_empty && (!r_valid || i_tready);
    assign o_valid = r_valid;
    assign o_word  = r_word;
    assign o_last  = r_last;

    always_comb begin
        if (i_fill_mode) begin
            val = i_entry.fg;
        end else begin
            val = (i_entry.fg & i_entry.aligned) | (i_entry.bg & ~i_entry.aligned);
        end
        n_word = (i_entry.old_dst & ~i_entry.mask) | (val & i_entry.mask);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
        end else if (i_tready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_word <= n_word;
            r_last <= i_entry.last;
        end
    end

endmodule

@@ rtl/planar_bitblt_word_combiner.sv @@
`timescale 1ns / 1ps
// Word combiner of a bit block transfer: one destination word in, one new
// destination word out, one word per cycle sustained while m_tready stays
// high. The front stage realigns the source through a three-word history
// and builds the edge masks as a word is accepted; a two-entry queue feeds
// the back stage, which applies the fg/bg (or solid fill) raster op and
// holds the result in an output register, so a word passes the queue and
// that register before m_tvalid rises. The user must write configuration
// through the plain write port while idle; the block does not enforce it.
module planar_bitblt_word_combiner import pbwc_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // src_word, src_word_second, old_dst_word, fg_word, bg_word, zero pad
    input  logic [S_DATA_W-1:0]   s_tdata,
    // first_word
    input  logic                  s_tuser,
    input  logic                  s_tlast,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // new_dst_word, zero pad
    output logic [M_DATA_W-1:0]   m_tdata,
    output logic                  m_tlast
);

    t_cfg                 r_cfg;
    t_entry               push_entry;
    t_entry               head_entry;
    t_q_ctl               q_ctl;
    logic                 push;
    logic                 pop;
    logic [WORD_BITS-1:0] out_word;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_we) begin
            unique case (t_reg_idx'(i_cfg_idx))
                REG_FILL_MODE:  r_cfg.fill_mode      <= i_cfg_wdata[0];
                REG_DST_OFFSET: r_cfg.dst_bit_offset <= i_cfg_wdata[OFS_BITS-1:0];
                REG_SRC_OFFSET: r_cfg.src_bit_offset <= i_cfg_wdata[OFS_BITS-1:0];
                REG_END_PAD:    r_cfg.end_pad_bits   <= i_cfg_wdata[OFS_BITS-1:0];
                default: ;
            endcase
        end
    end

    pbwc_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_first (s_tuser),
        .i_last  (s_tlast),
        .i_src   (s_tdata[0*WORD_BITS +: WORD_BITS]),
        .i_src2  (s_tdata[1*WORD_BITS +: WORD_BITS]),
        .i_old   (s_tdata[2*WORD_BITS +: WORD_BITS]),
        .i_fg    (s_tdata[3*WORD_BITS +: WORD_BITS]),
        .i_bg    (s_tdata[4*WORD_BITS +: WORD_BITS]),
        .i_valid (s_tvalid),
        .i_full  (q_ctl.full),
        .o_ready (s_tready),
        .o_push  (push),
        .o_entry (push_entry)
    );

    pbwc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_pop   (pop),
        .i_entry (push_entry),
        .o_entry (head_entry),
        .o_ctl   (q_ctl)
    );

    pbwc_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fill_mode (r_cfg.fill_mode),
        .i_entry     (head_entry),
        .i_empty     (q_ctl.empty),
        .i_tready    (m_tready),
        .o_pop       (pop),
        .o_valid     (m_tvalid),
        .o_word      (out_word),
        .o_last      (m_tlast)
    );

    assign m_tdata = M_DATA_W'(out_word);

endmodule

@@ tb/planar_bitblt_word_combiner_tb.sv @@
`timescale 1ns / 1ps
module planar_bitblt_word_combiner_tb;
    import pbwc_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int PHASES      = 12;
    localparam int PHASE_WORDS = 108;
    localparam int DIR_COUNT   = 16;
    localparam logic [WORD_BITS-1:0] ALL_ONES = '1;

    typedef struct packed {
        logic                 first;
        logic                 last;
        logic [WORD_BITS-1:0] src;
        logic [WORD_BITS-1:0] src2;
        logic [WORD_BITS-1:0] old_dst;
        logic [WORD_BITS-1:0] fg;
        logic [WORD_BITS-1:0] bg;
    } t_word;

    typedef struct packed {
        logic [WORD_BITS-1:0] dst;
        logic                 run_end;
    } t_result;

    typedef struct packed {
        t_word                w;
        logic                 known;
        logic [WORD_BITS-1:0] dst;
    } t_vector;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_wdata;
    logic                  s_tvalid;
    logic                  s_tready;
    // src_word, src_word_second, old_dst_word, fg_word, bg_word
    logic [S_DATA_W-1:0]   s_tdata;
    logic                  s_tuser;   // first_word
    logic                  s_tlast;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [M_DATA_W-1:0]   m_tdata;   // new_dst_word
    logic                  m_tlast;

    logic                  cfg_fill;
    logic [OFS_BITS-1:0]   cfg_dst;
    logic [OFS_BITS-1:0]   cfg_src;
    logic [OFS_BITS-1:0]   cfg_pad;
    logic [HIST_BITS-1:0]  src_hist;

    t_result               pending_dst[$];
    t_result               want;
    int                    mismatch_count;
    int                    cycle_count;
    int                    tx_idle_pct;
    int                    rx_idle_pct;
    int                    hold_left;

    planar_bitblt_word_combiner i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .s_tlast     (s_tlast),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    function automatic t_result combine_word(input t_word w);
        logic [WORD_BITS-1:0] mask;
        logic [WORD_BITS-1:0] aligned;
        logic [WORD_BITS-1:0] val;
        int                   rot;
        t_result              res;
        mask = ALL_ONES;
        if (w.first) begin
            src_hist = {{WORD_BITS{1'b0}}, w.src, w.src2};
            mask = mask & (ALL_ONES >> cfg_dst);
        end else begin
            src_hist = {src_hist[2*WORD_BITS-1:0], w.src};
        end
        if (w.last) begin
            mask = mask & (ALL_ONES << cfg_pad);
        end
        rot = ((int'(cfg_dst) - int'(cfg_src)) & (2 * WORD_BITS - 1)) ^ WORD_BITS;
        aligned = WORD_BITS'(src_hist >> rot);
        if (cfg_fill) begin
            val = w.fg;
        end else begin
            val = (w.fg & aligned) | (w.bg & ~aligned);
        end
        res.dst = (w.old_dst & ~mask) | (val & mask);
        res.run_end = w.last;
        return res;
    endfunction

    function automatic logic [WORD_BITS-1:0] rand_byte();
        case ($urandom_range(7))
            0: return '0;
            1: return ALL_ONES;
            default: return WORD_BITS'($urandom);
        endcase
    endfunction

    function automatic t_word rand_word();
        t_word w;
        w.first = 1'b0;
        w.last = 1'b0;
        w.src = rand_byte();
        w.src2 = rand_byte();
        w.old_dst = rand_byte();
        w.fg = rand_byte();
        w.bg = rand_byte();
        return w;
    endfunction

    task automatic report_mismatch(input string what, input logic [M_DATA_W-1:0] got,
                                   input logic [M_DATA_W-1:0] exp_val);
        if (mismatch_count < 40) begin
            $display("ERROR at %0t: %s: got %0h, want %0h", $time, what, got, exp_val);
        end
        mismatch_count++;
    endtask

    task automatic write_reg(input t_reg_idx idx, input logic [CFG_DATA_W-1:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        case (idx)
            REG_FILL_MODE:  cfg_fill = val[0];
            REG_DST_OFFSET: cfg_dst = val[OFS_BITS-1:0];
            REG_SRC_OFFSET: cfg_src = val[OFS_BITS-1:0];
            REG_END_PAD:    cfg_pad = val[OFS_BITS-1:0];
            default: ;
        endcase
    endtask

    task automatic set_config(input logic fill, input int dst, input int src, input int pad);
        write_reg(REG_FILL_MODE, CFG_DATA_W'($urandom_range(3) * 2 + fill));
        write_reg(REG_DST_OFFSET, CFG_DATA_W'(dst));
        write_reg(REG_SRC_OFFSET, CFG_DATA_W'(src));
        write_reg(REG_END_PAD, CFG_DATA_W'(pad));
        i_cfg_we <= 1'b0;
    endtask

    task automatic send_word(input t_word w, input logic known,
                             input logic [WORD_BITS-1:0] known_dst);
        t_result res;
        while ($urandom_range(99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= w.first;
        s_tlast <= w.last;
        s_tdata <= S_DATA_W'({w.bg, w.fg, w.old_dst, w.src2, w.src});
        do @(posedge i_clk); while (!s_tready);
        res = combine_word(w);
        if (known) begin
            res.dst = known_dst;
        end
        pending_dst.push_back(res);
    endtask

    task automatic drain_words();
        while (pending_dst.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_tvalid && m_tready) begin
            if (pending_dst.size() == 0) begin
                report_mismatch("word with none pending", m_tdata, '0);
            end else begin
                want = pending_dst.pop_front();
                if (m_tdata !== M_DATA_W'(want.dst)) begin
                    report_mismatch("new_dst_word", m_tdata, M_DATA_W'(want.dst));
                end
                if (m_tlast !== want.run_end) begin
                    report_mismatch("run_end", M_DATA_W'(m_tlast), M_DATA_W'(want.run_end));
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial begin
        t_vector directed [DIR_COUNT];
        t_word   w;
        int      words;
        int      len;
        directed = '{
            '{'{1'b1, 1'b1, 8'hFF, 8'h00, 8'h00, 8'hA5, 8'h5A}, 1'b1, 8'hA5},
            '{'{1'b1, 1'b0, 8'h00, 8'hFF, 8'hFF, 8'hA5, 8'h5A}, 1'b1, 8'h5A},
            '{'{1'b0, 1'b0, 8'h0F, 8'h00, 8'h00, 8'hFF, 8'h00}, 1'b1, 8'hFF},
            '{'{1'b0, 1'b1, 8'hF0, 8'h00, 8'hFF, 8'h00, 8'hFF}, 1'b1, 8'hF0},
            '{'{1'b1, 1'b1, 8'h00, 8'h00, 8'hFF, 8'h00, 8'h00}, 1'b1, 8'h00},
            '{'{1'b1, 1'b1, 8'h55, 8'hAA, 8'h00, 8'hFF, 8'h00}, 1'b1, 8'h55},
            '{'{1'b1, 1'b1, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF}, 1'b1, 8'hFF},
            '{'{1'b1, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}, 1'b1, 8'h00},
            '{'{1'b0, 1'b0, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'hFF}, 1'b0, 8'h00},
            '{'{1'b0, 1'b0, 8'h3C, 8'hC3, 8'h81, 8'hF0, 8'h0F}, 1'b0, 8'h00},
            '{'{1'b0, 1'b0, 8'hA5, 8'h5A, 8'h7E, 8'h18, 8'hE7}, 1'b0, 8'h00},
            '{'{1'b0, 1'b1, 8'h99, 8'h66, 8'h00, 8'hFF, 8'h00}, 1'b0, 8'h00},
            '{'{1'b0, 1'b1, 8'hC3, 8'h00, 8'hFF, 8'h00, 8'hFF}, 1'b0, 8'h00},
            '{'{1'b0, 1'b0, 8'h12, 8'h34, 8'h56, 8'h78, 8'h9A}, 1'b0, 8'h00},
            '{'{1'b1, 1'b1, 8'h80, 8'h01, 8'h7F, 8'h80, 8'h01}, 1'b0, 8'h00},
            '{'{1'b1, 1'b1, 8'h01, 8'h80, 8'h80, 8'h01, 8'h80}, 1'b0, 8'h00}
        };
        cfg_fill = 1'b0;
        cfg_dst = '0;
        cfg_src = '0;
        cfg_pad = '0;
        src_hist = '0;
        mismatch_count = 0;
        cycle_count = 0;
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        hold_left = 0;
        i_rst_n <= 1'b0;
        i_cfg_we <= 1'b0;
        i_cfg_idx <= REG_FILL_MODE;
        i_cfg_wdata <= '0;
        s_tvalid <= 1'b0;
        s_tdata <= '0;
        s_tuser <= 1'b0;
        s_tlast <= 1'b0;
        m_tready <= 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int i = 0; i < DIR_COUNT; i++) begin
            send_word(directed[i].w, directed[i].known, directed[i].dst);
        end
        s_tvalid <= 1'b0;

        for (int p = 0; p < PHASES; p++) begin
            drain_words();
            if (p < 4) begin
                tx_idle_pct = 17;
                rx_idle_pct = 53;
            end else if (p < 8) begin
                tx_idle_pct = 53;
                rx_idle_pct = 17;
            end else begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            case (p)
                0: set_config(1'b0, 7, 0, 7);
                1: set_config(1'b0, 0, 7, 0);
                2: set_config(1'b1, 7, 7, 7);
                3: set_config(1'b0, 0, 0, 0);
                default: set_config(1'($urandom_range(1)), $urandom_range(7),
                                    $urandom_range(7), $urandom_range(7));
            endcase
            if (p == 8) begin
                hold_left = 150;
            end
            words = 0;
            while (words < PHASE_WORDS) begin
                if ($urandom_range(9) == 0) begin
                    w = rand_word();
                    w.first = 1'($urandom);
                    w.last = 1'($urandom);
                    send_word(w, 1'b0, '0);
                    words++;
                end else begin
                    len = ($urandom_range(7) == 0) ? $urandom_range(9, 20)
                                                   : $urandom_range(1, 5);
                    for (int k = 0; k < len; k++) begin
                        w = rand_word();
                        w.first = (k == 0);
                        w.last = (k == len - 1);
                        send_word(w, 1'b0, '0);
                        words++;
                    end
                end
            end
            s_tvalid <= 1'b0;
        end

        drain_words();
        if (mismatch_count == 0 && pending_dst.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

@@ planar_bitblt_word_combiner.f @@
rtl/pbwc_pkg.sv
rtl/pbwc_front.sv
rtl/pbwc_queue.sv
rtl/pbwc_back.sv
rtl/planar_bitblt_word_combiner.sv
tb/planar_bitblt_word_combiner_tb.sv
